// ===== design/i2cee_pkg.sv =====
`default_nettype none

package i2cee_pkg;

  localparam int PAGE_BYTES_DEF = 256;
  localparam int MAX_RES        = 4;
  localparam int SLOT_W         = $clog2(MAX_RES);

  localparam logic [7:0] DEV_ADDR_RST = 8'd160;
  localparam logic [9:0] WC_TICKS_RST = 10'd5;
  localparam logic [9:0] ELAPSED_MAX  = 10'd1023;

  localparam logic CFG_DEV_ADDR = 1'b0;
  localparam logic CFG_WC_TICKS = 1'b1;

  typedef enum logic [2:0] {
    K_BEGIN_RD = 3'd0,
    K_BEGIN_WR = 3'd1,
    K_EVENT    = 3'd2,
    K_TICK     = 3'd3,
    K_ERROR    = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ACT_NONE   = 4'd0,
    ACT_START  = 4'd1,
    ACT_SEND   = 4'd2,
    ACT_STOP   = 4'd3,
    ACT_ACKOFF = 4'd4,
    ACT_POSON  = 4'd5,
    ACT_BYTE   = 4'd6,
    ACT_DONE   = 4'd7,
    ACT_ABORT  = 4'd8
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START   = 4'd1,
    PH_DEV     = 4'd2,
    PH_AHI     = 4'd3,
    PH_ALO     = 4'd4,
    PH_RSTART  = 4'd5,
    PH_RDEV    = 4'd6,
    PH_MULTI   = 4'd7,
    PH_SINGLE  = 4'd8,
    PH_WRITING = 4'd9,
    PH_WLAST   = 4'd10
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [16:0] mem_address;
    logic [8:0]  length;
    logic [7:0]  status_flags;
    logic [7:0]  rx_first;
    logic [7:0]  rx_second;
    logic [7:0]  tx_byte;
  } item_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] data;
    logic [8:0] idx;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [SLOT_W-1:0]  cnt;
    logic               busy;
    logic               wca;
    logic [9:0]         left;
  } bundle_t;

endpackage

`default_nettype wire

// ===== design/i2cee_in_if.sv =====
`default_nettype none

interface i2cee_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [16:0] mem_address;
  logic [8:0]  length;
  logic [7:0]  status_flags;
  logic [7:0]  rx_first;
  logic [7:0]  rx_second;
  logic [7:0]  tx_byte;

  modport source (output valid, kind, mem_address, length, status_flags, rx_first,
                  rx_second, tx_byte, input ready);
  modport sink (input valid, kind, mem_address, length, status_flags, rx_first,
                rx_second, tx_byte, output ready);
endinterface

`default_nettype wire

// ===== design/i2cee_out_if.sv =====
`default_nettype none

interface i2cee_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] action;
  logic [7:0] out_byte;
  logic [8:0] byte_index;
  logic       busy_res;
  logic       write_cycle_active;
  logic [9:0] ticks_left;
  logic       last;

  modport source (output valid, action, out_byte, byte_index, busy_res,
                  write_cycle_active, ticks_left, last, input ready);
  modport sink (input valid, action, out_byte, byte_index, busy_res,
                write_cycle_active, ticks_left, last, output ready);
endinterface

`default_nettype wire

// ===== design/i2cee_ctrl.sv =====
`default_nettype none

module i2cee_ctrl #(
  parameter int PAGE_BYTES = i2cee_pkg::PAGE_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire i2cee_pkg::item_t  item,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [9:0]        cfg_data,
  output i2cee_pkg::bundle_t     bundle
);

  localparam int PW = $clog2(PAGE_BYTES + 1);
  localparam int CW = (PW > 9) ? PW : 9;
  localparam logic [CW-1:0] PAGE_C = CW'(PAGE_BYTES);

  i2cee_pkg::phase_t phase_r, phase_nxt;
  logic          rd_r, rd_nxt;
  logic [15:0]   off_r, off_nxt;
  logic          blk_r, blk_nxt;
  logic [PW-1:0] len_r, len_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] rem_r, rem_nxt;
  logic          wa_r, wa_nxt;
  logic [9:0]    wel_r, wel_nxt;
  logic [7:0]    dev_r;
  logic [9:0]    wct_r;

  logic          flag_hit;
  logic          idle;
  logic [PW-1:0] pos_inc;
  logic [PW-1:0] pos_inc2;
  logic [PW-1:0] rem1;
  logic [PW-1:0] rem2;
  logic [CW-1:0] len_w;
  logic [CW-1:0] len_c;
  logic [9:0]    wel_inc;

  function automatic logic [8:0] idx9(input logic [PW-1:0] p);
    logic [CW-1:0] w;
    w = CW'(p);
    return w[8:0];
  endfunction

  function automatic i2cee_pkg::res_t mk(input i2cee_pkg::action_t a, input logic [7:0] d,
                                         input logic [8:0] i);
    i2cee_pkg::res_t r;
    r.action = a;
    r.data   = d;
    r.idx    = i;
    return r;
  endfunction

  assign idle     = (phase_r == i2cee_pkg::PH_IDLE);
  assign pos_inc  = pos_r + PW'(1);
  assign pos_inc2 = pos_r + PW'(2);
  assign rem1     = (rem_r != '0) ? rem_r - PW'(1) : rem_r;
  assign rem2     = (rem1 != '0) ? rem1 - PW'(1) : rem1;
  assign wel_inc  = (wel_r < i2cee_pkg::ELAPSED_MAX) ? wel_r + 10'd1 : wel_r;

  always_comb begin
    len_w = CW'(item.length);
    if (len_w == '0) begin
      len_c = CW'(1);
    end else if (len_w > PAGE_C) begin
      len_c = PAGE_C;
    end else begin
      len_c = len_w;
    end
  end

  always_comb begin
    case (phase_r)
      i2cee_pkg::PH_START, i2cee_pkg::PH_RSTART: flag_hit = item.status_flags[0];
      i2cee_pkg::PH_DEV, i2cee_pkg::PH_RDEV:     flag_hit = item.status_flags[1];
      i2cee_pkg::PH_AHI, i2cee_pkg::PH_ALO,
      i2cee_pkg::PH_MULTI:                        flag_hit = item.status_flags[2];
      i2cee_pkg::PH_SINGLE:                       flag_hit = item.status_flags[6];
      i2cee_pkg::PH_WRITING: flag_hit = item.status_flags[7] | item.status_flags[2];
      i2cee_pkg::PH_WLAST:                        flag_hit = 1'b1;
      default:                                    flag_hit = 1'b0;
    endcase
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      case (item.kind)
        i2cee_pkg::K_BEGIN_RD, i2cee_pkg::K_BEGIN_WR: begin
          if (idle) phase_nxt = i2cee_pkg::PH_START;
        end
        i2cee_pkg::K_EVENT: begin
          if (flag_hit) begin
            case (phase_r)
              i2cee_pkg::PH_START:  phase_nxt = i2cee_pkg::PH_DEV;
              i2cee_pkg::PH_DEV:    phase_nxt = i2cee_pkg::PH_AHI;
              i2cee_pkg::PH_AHI:
                phase_nxt = rd_r ? i2cee_pkg::PH_ALO : i2cee_pkg::PH_WRITING;
              i2cee_pkg::PH_ALO:    phase_nxt = i2cee_pkg::PH_RSTART;
              i2cee_pkg::PH_RSTART: phase_nxt = i2cee_pkg::PH_RDEV;
              i2cee_pkg::PH_RDEV:
                phase_nxt = (len_r == PW'(1)) ? i2cee_pkg::PH_SINGLE : i2cee_pkg::PH_MULTI;
              i2cee_pkg::PH_MULTI: begin
                if (len_r == PW'(2)) begin
                  phase_nxt = i2cee_pkg::PH_IDLE;
                end else if (rem_r > PW'(3)) begin
                  phase_nxt = i2cee_pkg::PH_MULTI;
                end else begin
                  phase_nxt = i2cee_pkg::PH_SINGLE;
                end
              end
              i2cee_pkg::PH_SINGLE: phase_nxt = i2cee_pkg::PH_IDLE;
              i2cee_pkg::PH_WRITING: begin
                if (pos_inc >= len_r) phase_nxt = i2cee_pkg::PH_WLAST;
              end
              i2cee_pkg::PH_WLAST:  phase_nxt = i2cee_pkg::PH_IDLE;
              default:              phase_nxt = phase_r;
            endcase
          end
        end
        i2cee_pkg::K_ERROR: phase_nxt = i2cee_pkg::PH_IDLE;
        default:            phase_nxt = phase_r;
      endcase
    end
  end

  // datapath and results
  always_comb begin
    rd_nxt  = rd_r;
    off_nxt = off_r;
    blk_nxt = blk_r;
    len_nxt = len_r;
    pos_nxt = pos_r;
    rem_nxt = rem_r;
    wa_nxt  = wa_r;
    wel_nxt = wel_r;
    bundle.res = '0;
    bundle.res[0] = mk(i2cee_pkg::ACT_NONE, 8'd0, idx9(pos_r));
    bundle.cnt = '0;
    if (acc) begin
      case (item.kind)
        i2cee_pkg::K_BEGIN_RD, i2cee_pkg::K_BEGIN_WR: begin
          if (idle) begin
            rd_nxt  = (item.kind == i2cee_pkg::K_BEGIN_RD);
            off_nxt = item.mem_address[15:0];
            blk_nxt = item.mem_address[16];
            len_nxt = PW'(len_c);
            rem_nxt = PW'(len_c);
            pos_nxt = '0;
            bundle.res[0] = mk(i2cee_pkg::ACT_START, 8'd0, 9'd0);
          end
        end
        i2cee_pkg::K_EVENT: begin
          if (flag_hit) begin
            case (phase_r)
              i2cee_pkg::PH_START:
                bundle.res[0] = mk(i2cee_pkg::ACT_SEND,
                                   {dev_r[7:2], dev_r[1] | blk_r, 1'b0}, idx9(pos_r));
              i2cee_pkg::PH_DEV:
                bundle.res[0] = mk(i2cee_pkg::ACT_SEND, off_r[15:8], idx9(pos_r));
              i2cee_pkg::PH_AHI:
                bundle.res[0] = mk(i2cee_pkg::ACT_SEND, off_r[7:0], idx9(pos_r));
              i2cee_pkg::PH_ALO:
                bundle.res[0] = mk(i2cee_pkg::ACT_START, 8'd0, idx9(pos_r));
              i2cee_pkg::PH_RSTART:
                bundle.res[0] = mk(i2cee_pkg::ACT_SEND,
                                   {dev_r[7:2], dev_r[1] | blk_r, 1'b1}, idx9(pos_r));
              i2cee_pkg::PH_RDEV: begin
                if (len_r == PW'(1)) begin
                  bundle.res[0] = mk(i2cee_pkg::ACT_ACKOFF, 8'd0, idx9(pos_r));
                  bundle.res[1] = mk(i2cee_pkg::ACT_STOP, 8'd0, idx9(pos_r));
                  bundle.cnt    = i2cee_pkg::SLOT_W'(1);
                end else if (len_r == PW'(2)) begin
                  bundle.res[0] = mk(i2cee_pkg::ACT_POSON, 8'd0, idx9(pos_r));
                  bundle.res[1] = mk(i2cee_pkg::ACT_ACKOFF, 8'd0, idx9(pos_r));
                  bundle.cnt    = i2cee_pkg::SLOT_W'(1);
                end
              end
              i2cee_pkg::PH_MULTI: begin
                if (len_r == PW'(2)) begin
                  bundle.res[0] = mk(i2cee_pkg::ACT_STOP, 8'd0, idx9(pos_r));
                  bundle.res[1] = mk(i2cee_pkg::ACT_BYTE, item.rx_first, 9'd0);
                  bundle.res[2] = mk(i2cee_pkg::ACT_BYTE, item.rx_second, 9'd1);
                  bundle.res[3] = mk(i2cee_pkg::ACT_DONE, 8'd0, 9'd2);
                  bundle.cnt    = i2cee_pkg::SLOT_W'(3);
                  pos_nxt = PW'(2);
                  rem_nxt = '0;
                end else if (rem_r > PW'(3)) begin
                  bundle.res[0] = mk(i2cee_pkg::ACT_BYTE, item.rx_first, idx9(pos_r));
                  pos_nxt = pos_inc;
                  rem_nxt = rem_r - PW'(1);
                end else begin
                  bundle.res[0] = mk(i2cee_pkg::ACT_ACKOFF, 8'd0, idx9(pos_r));
                  bundle.res[1] = mk(i2cee_pkg::ACT_BYTE, item.rx_first, idx9(pos_r));
                  bundle.res[2] = mk(i2cee_pkg::ACT_STOP, 8'd0, idx9(pos_inc));
                  bundle.res[3] = mk(i2cee_pkg::ACT_BYTE, item.rx_second, idx9(pos_inc));
                  bundle.cnt    = i2cee_pkg::SLOT_W'(3);
                  pos_nxt = pos_inc2;
                  rem_nxt = rem2;
                end
              end
              i2cee_pkg::PH_SINGLE: begin
                bundle.res[0] = mk(i2cee_pkg::ACT_BYTE, item.rx_first, idx9(pos_r));
                bundle.res[1] = mk(i2cee_pkg::ACT_DONE, 8'd0, idx9(pos_r));
                bundle.cnt    = i2cee_pkg::SLOT_W'(1);
                rem_nxt = rem1;
              end
              i2cee_pkg::PH_WRITING: begin
                bundle.res[0] = mk(i2cee_pkg::ACT_SEND, item.tx_byte, idx9(pos_inc));
                pos_nxt = pos_inc;
              end
              i2cee_pkg::PH_WLAST: begin
                bundle.res[0] = mk(i2cee_pkg::ACT_STOP, 8'd0, idx9(pos_r));
                bundle.res[1] = mk(i2cee_pkg::ACT_DONE, 8'd0, idx9(pos_r));
                bundle.cnt    = i2cee_pkg::SLOT_W'(1);
                wa_nxt  = 1'b1;
                wel_nxt = '0;
              end
              default: ;
            endcase
          end
        end
        i2cee_pkg::K_TICK: begin
          if (wa_r) begin
            if (wel_inc >= wct_r) begin
              wa_nxt  = 1'b0;
              wel_nxt = '0;
            end else begin
              wel_nxt = wel_inc;
            end
          end
        end
        i2cee_pkg::K_ERROR: begin
          if (!idle) bundle.res[0] = mk(i2cee_pkg::ACT_ABORT, 8'd0, idx9(pos_r));
        end
        default: ;
      endcase
    end
    bundle.busy = (phase_nxt != i2cee_pkg::PH_IDLE);
    bundle.wca  = wa_nxt;
    bundle.left = (wa_nxt && (wel_nxt < wct_r)) ? wct_r - wel_nxt : 10'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2cee_pkg::PH_IDLE;
      rd_r    <= 1'b0;
      off_r   <= '0;
      blk_r   <= 1'b0;
      len_r   <= '0;
      pos_r   <= '0;
      rem_r   <= '0;
      wa_r    <= 1'b0;
      wel_r   <= '0;
      dev_r   <= i2cee_pkg::DEV_ADDR_RST;
      wct_r   <= i2cee_pkg::WC_TICKS_RST;
    end else begin
      phase_r <= phase_nxt;
      rd_r    <= rd_nxt;
      off_r   <= off_nxt;
      blk_r   <= blk_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      rem_r   <= rem_nxt;
      wa_r    <= wa_nxt;
      wel_r   <= wel_nxt;
      if (cfg_we) begin
        case (cfg_index)
          i2cee_pkg::CFG_DEV_ADDR: dev_r <= cfg_data[7:0];
          i2cee_pkg::CFG_WC_TICKS: wct_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTH
  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc && item.kind == i2cee_pkg::K_ERROR |=> phase_r == i2cee_pkg::PH_IDLE)
    else $error("error item did not return to idle");
  a_wel_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !wa_r |-> wel_r == '0)
    else $error("elapsed count set with no write cycle");
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= len_r)
    else $error("byte position beyond transfer length");
  a_wlast_done: assert property (@(posedge clk) disable iff (!rst_n)
    acc && item.kind == i2cee_pkg::K_EVENT && phase_r == i2cee_pkg::PH_WLAST |=> wa_r)
    else $error("write end did not start write cycle");
`endif

endmodule

`default_nettype wire

// ===== design/i2cee_outbuf.sv =====
`default_nettype none

module i2cee_outbuf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire i2cee_pkg::bundle_t bundle,
  output logic                    space,
  i2cee_out_if.source             out_if
);

  i2cee_pkg::bundle_t          bundle_r;
  logic                        full_r, full_nxt;
  logic [i2cee_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic                        at_last;
  logic                        take;
  i2cee_pkg::res_t             cur;

  assign at_last = (slot_r == bundle_r.cnt);
  assign take    = full_r && out_if.ready;
  assign space   = !full_r || (out_if.ready && at_last);
  assign cur     = bundle_r.res[slot_r];

  assign out_if.valid              = full_r;
  assign out_if.action             = cur.action;
  assign out_if.out_byte           = cur.data;
  assign out_if.byte_index         = cur.idx;
  assign out_if.busy_res           = bundle_r.busy;
  assign out_if.write_cycle_active = bundle_r.wca;
  assign out_if.ticks_left         = bundle_r.left;
  assign out_if.last               = at_last;

  always_comb begin
    full_nxt = full_r;
    slot_nxt = slot_r;
    if (load) begin
      full_nxt = 1'b1;
      slot_nxt = '0;
    end else if (take) begin
      if (at_last) begin
        full_nxt = 1'b0;
        slot_nxt = '0;
      end else begin
        slot_nxt = slot_r + i2cee_pkg::SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      slot_r <= '0;
    end else begin
      full_r <= full_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) bundle_r <= bundle;
  end

`ifndef SYNTH
  a_load_space: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> space)
    else $error("bundle loaded over undelivered results");
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> slot_r <= bundle_r.cnt)
    else $error("result slot beyond bundle count");
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !full_r |-> slot_r == '0)
    else $error("slot not cleared while empty");
`endif

endmodule

`default_nettype wire

// ===== design/i2c_eeprom_transfer_sequencer.sv =====
// Channel   Dir  Handshake      Payload
// in_if     in   valid/ready    kind, mem_address, length, status_flags, rx_first,
//                               rx_second, tx_byte
// out_if    out  valid/ready    action, out_byte, byte_index, busy_res,
//                               write_cycle_active, ticks_left, last
// cfg_*     in   cfg_we         cfg_index, cfg_data
//
// An item is decoded in the cycle it is accepted; its 1 to 4 results sit in
// the result register and leave one per cycle while out_if is ready, the first
// offered in the next cycle, so single-result items pass at 1 item per cycle. A
// new item is taken in the cycle the last result of the previous one is taken.
// Reset is synchronous, active low, and clears sequencing state and
// configuration to defaults; no clearing pass.
`default_nettype none

module i2c_eeprom_transfer_sequencer #(
  parameter int PAGE_BYTES = i2cee_pkg::PAGE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  i2cee_in_if.sink         in_if,
  i2cee_out_if.source      out_if,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [9:0]  cfg_data
);

  i2cee_pkg::item_t   item;
  i2cee_pkg::bundle_t bundle;
  logic               space;
  logic               acc;

  assign in_if.ready = space;
  assign acc         = in_if.valid && space;

  assign item.kind         = i2cee_pkg::kind_t'(in_if.kind);
  assign item.mem_address  = in_if.mem_address;
  assign item.length       = in_if.length;
  assign item.status_flags = in_if.status_flags;
  assign item.rx_first     = in_if.rx_first;
  assign item.rx_second    = in_if.rx_second;
  assign item.tx_byte      = in_if.tx_byte;

  i2cee_ctrl #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bundle    (bundle)
  );

  i2cee_outbuf u_outbuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (acc),
    .bundle (bundle),
    .space  (space),
    .out_if (out_if)
  );

endmodule

`default_nettype wire

// ===== test/i2c_eeprom_transfer_sequencer_tb.sv =====
module i2c_eeprom_transfer_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    i2cee_pkg::action_t action;
    logic [7:0]         out_byte;
    logic [8:0]         byte_index;
    logic               busy;
    logic               wc_active;
    logic [9:0]         ticks_left;
    logic               last;
  } cmd_t;

  class command_scoreboard;
    logic [7:0]        dev_addr;
    logic [9:0]        wc_ticks;
    i2cee_pkg::phase_t phase;
    bit                reading;
    logic [15:0]       offset;
    bit                blk;
    int unsigned       len, pos, remaining, elapsed;
    bit                wc_on;
    cmd_t              expected_cmds[$];
    cmd_t              batch[$];
    int                mismatches, checked, n_items, n_done, n_abort;

    function new();
      dev_addr = i2cee_pkg::DEV_ADDR_RST;
      wc_ticks = i2cee_pkg::WC_TICKS_RST;
      phase = i2cee_pkg::PH_IDLE;
      reading = 0;
      offset = '0;
      blk = 0;
      len = 0;
      pos = 0;
      remaining = 0;
      elapsed = 0;
      wc_on = 0;
    endfunction

    function void write_reg(logic idx, logic [9:0] val);
      if (idx == i2cee_pkg::CFG_DEV_ADDR) dev_addr = val[7:0];
      else wc_ticks = val;
    endfunction

    function void add(i2cee_pkg::action_t a, logic [7:0] b, int unsigned idx);
      cmd_t c;
      c = '0;
      c.action = a;
      c.out_byte = b;
      c.byte_index = idx[8:0];
      batch.push_back(c);
      if (a == i2cee_pkg::ACT_DONE) n_done++;
      if (a == i2cee_pkg::ACT_ABORT) n_abort++;
    endfunction

    function logic [7:0] dev_byte(bit rd);
      return {dev_addr[7:2], dev_addr[1] | blk, rd};
    endfunction

    function void bus_event(logic [7:0] fl, logic [7:0] rx1, logic [7:0] rx2,
                            logic [7:0] tx);
      case (phase)
        i2cee_pkg::PH_START: if (fl[0]) begin
          add(i2cee_pkg::ACT_SEND, dev_byte(1'b0), pos);
          phase = i2cee_pkg::PH_DEV;
        end
        i2cee_pkg::PH_DEV: if (fl[1]) begin
          add(i2cee_pkg::ACT_SEND, offset[15:8], pos);
          phase = i2cee_pkg::PH_AHI;
        end
        i2cee_pkg::PH_AHI: if (fl[2]) begin
          add(i2cee_pkg::ACT_SEND, offset[7:0], pos);
          phase = reading ? i2cee_pkg::PH_ALO : i2cee_pkg::PH_WRITING;
        end
        i2cee_pkg::PH_ALO: if (fl[2]) begin
          add(i2cee_pkg::ACT_START, 8'd0, pos);
          phase = i2cee_pkg::PH_RSTART;
        end
        i2cee_pkg::PH_RSTART: if (fl[0]) begin
          add(i2cee_pkg::ACT_SEND, dev_byte(1'b1), pos);
          phase = i2cee_pkg::PH_RDEV;
        end
        i2cee_pkg::PH_RDEV: if (fl[1]) begin
          if (len == 1) begin
            add(i2cee_pkg::ACT_ACKOFF, 8'd0, pos);
            add(i2cee_pkg::ACT_STOP, 8'd0, pos);
            phase = i2cee_pkg::PH_SINGLE;
          end else begin
            if (len == 2) begin
              add(i2cee_pkg::ACT_POSON, 8'd0, pos);
              add(i2cee_pkg::ACT_ACKOFF, 8'd0, pos);
            end
            phase = i2cee_pkg::PH_MULTI;
          end
        end
        i2cee_pkg::PH_MULTI: if (fl[2]) begin
          if (len == 2) begin
            add(i2cee_pkg::ACT_STOP, 8'd0, pos);
            add(i2cee_pkg::ACT_BYTE, rx1, 0);
            add(i2cee_pkg::ACT_BYTE, rx2, 1);
            pos = 2;
            remaining = 0;
            add(i2cee_pkg::ACT_DONE, 8'd0, pos);
            phase = i2cee_pkg::PH_IDLE;
          end else if (remaining > 3) begin
            add(i2cee_pkg::ACT_BYTE, rx1, pos);
            pos++;
            remaining--;
          end else begin
            add(i2cee_pkg::ACT_ACKOFF, 8'd0, pos);
            add(i2cee_pkg::ACT_BYTE, rx1, pos);
            pos++;
            if (remaining > 0) remaining--;
            add(i2cee_pkg::ACT_STOP, 8'd0, pos);
            add(i2cee_pkg::ACT_BYTE, rx2, pos);
            pos++;
            if (remaining > 0) remaining--;
            phase = i2cee_pkg::PH_SINGLE;
          end
        end
        i2cee_pkg::PH_SINGLE: if (fl[6]) begin
          add(i2cee_pkg::ACT_BYTE, rx1, pos);
          add(i2cee_pkg::ACT_DONE, 8'd0, pos);
          if (remaining > 0) remaining--;
          phase = i2cee_pkg::PH_IDLE;
        end
        i2cee_pkg::PH_WRITING: if (fl[7] || fl[2]) begin
          pos = (pos + 1) & 32'h3FF;
          add(i2cee_pkg::ACT_SEND, tx, pos);
          if (pos >= len) phase = i2cee_pkg::PH_WLAST;
        end
        i2cee_pkg::PH_WLAST: begin
          add(i2cee_pkg::ACT_STOP, 8'd0, pos);
          wc_on = 1;
          elapsed = 0;
          add(i2cee_pkg::ACT_DONE, 8'd0, pos);
          phase = i2cee_pkg::PH_IDLE;
        end
        default: ;
      endcase
    endfunction

    // returns 1 when the item yields a command, not just a status report
    function bit predict_commands(i2cee_pkg::item_t it);
      logic [9:0] left;
      bit         acted;
      batch.delete();
      n_items++;
      case (it.kind)
        i2cee_pkg::K_BEGIN_RD, i2cee_pkg::K_BEGIN_WR: if (phase == i2cee_pkg::PH_IDLE) begin
          len = (it.length == 0) ? 1 : it.length;
          if (len > i2cee_pkg::PAGE_BYTES_DEF) len = i2cee_pkg::PAGE_BYTES_DEF;
          offset = it.mem_address[15:0];
          blk = it.mem_address[16];
          reading = (it.kind == i2cee_pkg::K_BEGIN_RD);
          remaining = len;
          pos = 0;
          phase = i2cee_pkg::PH_START;
          add(i2cee_pkg::ACT_START, 8'd0, pos);
        end
        i2cee_pkg::K_EVENT:
          bus_event(it.status_flags, it.rx_first, it.rx_second, it.tx_byte);
        i2cee_pkg::K_TICK: if (wc_on) begin
          if (elapsed < i2cee_pkg::ELAPSED_MAX) elapsed++;
          if (elapsed >= wc_ticks) begin
            wc_on = 0;
            elapsed = 0;
          end
        end
        i2cee_pkg::K_ERROR: if (phase != i2cee_pkg::PH_IDLE) begin
          phase = i2cee_pkg::PH_IDLE;
          add(i2cee_pkg::ACT_ABORT, 8'd0, pos);
        end
        default: ;
      endcase
      acted = (batch.size() != 0);
      if (!acted) add(i2cee_pkg::ACT_NONE, 8'd0, pos);
      left = (wc_on && elapsed < wc_ticks) ? wc_ticks - elapsed[9:0] : 10'd0;
      foreach (batch[k]) begin
        batch[k].busy = (phase != i2cee_pkg::PH_IDLE);
        batch[k].wc_active = wc_on;
        batch[k].ticks_left = left;
        batch[k].last = (k == batch.size() - 1);
        expected_cmds.push_back(batch[k]);
      end
      return acted;
    endfunction

    function void check_command(cmd_t got);
      cmd_t want;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected command act=%0d byte=%02h idx=%0d", $realtime,
                   got.action, got.out_byte, got.byte_index);
        return;
      end
      want = expected_cmds.pop_front();
      checked++;
      if (want.action != got.action || want.out_byte != got.out_byte ||
          want.byte_index != got.byte_index || want.busy != got.busy ||
          want.wc_active != got.wc_active || want.ticks_left != got.ticks_left ||
          want.last != got.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: command mismatch", $realtime);
          $display("  exp act=%0d byte=%02h idx=%0d busy=%0b wc=%0b left=%0d last=%0b",
                   want.action, want.out_byte, want.byte_index, want.busy,
                   want.wc_active, want.ticks_left, want.last);
          $display("  got act=%0d byte=%02h idx=%0d busy=%0b wc=%0b left=%0d last=%0b",
                   got.action, got.out_byte, got.byte_index, got.busy,
                   got.wc_active, got.ticks_left, got.last);
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [9:0] cfg_data;

  i2cee_in_if  in_ch ();
  i2cee_out_if out_ch ();

  i2c_eeprom_transfer_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  command_scoreboard sb = new();
  bit idling;
  int rx_hold;
  int useful;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles", CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ch.ready = 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        out_ch.ready = 1'b0;
        stall = $urandom_range(1, 17) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    cmd_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.action = i2cee_pkg::action_t'(out_ch.action);
      got.out_byte = out_ch.out_byte;
      got.byte_index = out_ch.byte_index;
      got.busy = out_ch.busy_res;
      got.wc_active = out_ch.write_cycle_active;
      got.ticks_left = out_ch.ticks_left;
      got.last = out_ch.last;
      sb.check_command(got);
    end
  end

  function automatic i2cee_pkg::item_t mk_item(i2cee_pkg::kind_t k);
    i2cee_pkg::item_t it;
    it.kind = k;
    it.mem_address = 17'($urandom);
    it.length = 9'($urandom);
    it.status_flags = 8'($urandom);
    it.rx_first = 8'($urandom);
    it.rx_second = 8'($urandom);
    it.tx_byte = 8'($urandom);
    return it;
  endfunction

  function automatic i2cee_pkg::item_t event_item(logic [7:0] flags);
    i2cee_pkg::item_t it;
    it = mk_item(i2cee_pkg::K_EVENT);
    it.status_flags = flags;
    return it;
  endfunction

  function automatic i2cee_pkg::item_t begin_item(i2cee_pkg::kind_t k, logic [16:0] addr,
                                                  logic [8:0] len);
    i2cee_pkg::item_t it;
    it = mk_item(k);
    it.mem_address = addr;
    it.length = len;
    return it;
  endfunction

  function automatic logic [7:0] awaited(i2cee_pkg::phase_t p);
    case (p)
      i2cee_pkg::PH_START, i2cee_pkg::PH_RSTART:                  return 8'h01;
      i2cee_pkg::PH_DEV, i2cee_pkg::PH_RDEV:                      return 8'h02;
      i2cee_pkg::PH_AHI, i2cee_pkg::PH_ALO, i2cee_pkg::PH_MULTI:  return 8'h04;
      i2cee_pkg::PH_SINGLE:                                       return 8'h40;
      i2cee_pkg::PH_WRITING:                                      return 8'h84;
      default:                                                    return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] good_flags(i2cee_pkg::phase_t p);
    logic [7:0] f;
    f = 8'($urandom);
    if (p == i2cee_pkg::PH_WRITING) begin
      case ($urandom_range(0, 2))
        0: f[7] = 1'b1;
        1: f[2] = 1'b1;
        default: f = f | 8'h84;
      endcase
    end else begin
      f = f | awaited(p);
    end
    return f;
  endfunction

  task automatic send_item(i2cee_pkg::item_t it);
    int gap;
    gap = (idling && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.kind = it.kind;
    in_ch.mem_address = it.mem_address;
    in_ch.length = it.length;
    in_ch.status_flags = it.status_flags;
    in_ch.rx_first = it.rx_first;
    in_ch.rx_second = it.rx_second;
    in_ch.tx_byte = it.tx_byte;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (sb.predict_commands(it)) useful++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.expected_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    if (sb.phase != i2cee_pkg::PH_IDLE) send_item(mk_item(i2cee_pkg::K_ERROR));
    wait_drained();
  endtask

  task automatic write_reg(logic idx, logic [9:0] val);
    @(negedge clk);
    in_ch.valid = 1'b0;
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic finish_transfer(int max_events, bit noisy);
    int n;
    int r;
    n = 0;
    while (sb.phase != i2cee_pkg::PH_IDLE) begin
      if (n >= max_events) begin
        send_item(mk_item(i2cee_pkg::K_ERROR));
        break;
      end
      r = noisy ? $urandom_range(0, 59) : 99;
      if (r < 5) send_item(event_item(8'($urandom) & ~awaited(sb.phase)));
      else if (r < 7) send_item(mk_item(i2cee_pkg::K_ERROR));
      else if (r < 9) send_item(mk_item(i2cee_pkg::K_TICK));
      else if (r < 10) send_item(mk_item(i2cee_pkg::K_BEGIN_RD));
      else if (r < 11) send_item(mk_item(i2cee_pkg::kind_t'($urandom_range(5, 7))));
      else send_item(event_item(good_flags(sb.phase)));
      n++;
    end
  endtask

  task automatic run_transfer(i2cee_pkg::kind_t k, logic [16:0] addr, logic [8:0] len,
                              int max_events, bit noisy);
    send_item(begin_item(k, addr, len));
    finish_transfer(max_events, noisy);
  endtask

  function automatic logic [8:0] pick_len();
    case ($urandom_range(0, 15))
      0:       return 9'd0;
      1:       return 9'($urandom_range(7, 12));
      default: return 9'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic random_sequence();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      run_transfer(i2cee_pkg::K_BEGIN_RD, 17'($urandom), pick_len(), 40, 1'b1);
    end else if (r < 8) begin
      run_transfer(i2cee_pkg::K_BEGIN_WR, 17'($urandom), pick_len(), 40, 1'b1);
      repeat ($urandom_range(0, 6)) send_item(mk_item(i2cee_pkg::K_TICK));
    end else begin
      repeat ($urandom_range(1, 3))
        send_item(mk_item(i2cee_pkg::kind_t'($urandom_range(0, 7))));
    end
  endtask

  task automatic random_phase(int target, bit allow_idle);
    int start;
    start = useful;
    while (useful - start < target) begin
      idling = allow_idle && ($urandom_range(0, 3) != 0);
      random_sequence();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = i2cee_pkg::CFG_DEV_ADDR;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = i2cee_pkg::K_BEGIN_RD;
    in_ch.mem_address = '0;
    in_ch.length = '0;
    in_ch.status_flags = '0;
    in_ch.rx_first = '0;
    in_ch.rx_second = '0;
    in_ch.tx_byte = '0;
    idling = 1'b0;
    rx_hold = 0;
    useful = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // idle, ignored items
    send_item(event_item(8'hFF));
    send_item(mk_item(i2cee_pkg::K_ERROR));
    send_item(mk_item(i2cee_pkg::K_TICK));
    send_item(mk_item(i2cee_pkg::kind_t'(3'd7)));
    // one-byte read at the top address, begin while busy
    send_item(begin_item(i2cee_pkg::K_BEGIN_RD, 17'h1FFFF, 9'd1));
    send_item(begin_item(i2cee_pkg::K_BEGIN_WR, 17'h00000, 9'd2));
    finish_transfer(20, 1'b0);
    // zero length write, start flag missing
    send_item(begin_item(i2cee_pkg::K_BEGIN_WR, 17'h00000, 9'd0));
    send_item(event_item(8'hFE));
    finish_transfer(20, 1'b0);
    send_item(mk_item(i2cee_pkg::K_TICK));
    send_item(mk_item(i2cee_pkg::K_TICK));
    // oversized length, aborted by a bus error
    send_item(begin_item(i2cee_pkg::K_BEGIN_RD, 17'h0FF00, 9'd511));
    send_item(event_item(8'h01));
    send_item(mk_item(i2cee_pkg::K_ERROR));

    settle();
    write_reg(i2cee_pkg::CFG_DEV_ADDR, 10'd0);
    write_reg(i2cee_pkg::CFG_WC_TICKS, 10'd0);
    random_phase(25, 1'b1);

    settle();
    write_reg(i2cee_pkg::CFG_DEV_ADDR, 10'd254);
    write_reg(i2cee_pkg::CFG_WC_TICKS, 10'd1023);
    idling = 1'b1;
    run_transfer(i2cee_pkg::K_BEGIN_WR, 17'($urandom), 9'd9, 400, 1'b0);
    repeat (3) send_item(mk_item(i2cee_pkg::K_TICK));
    wait_drained();
    write_reg(i2cee_pkg::CFG_WC_TICKS, 10'd2);
    repeat (2) send_item(mk_item(i2cee_pkg::K_TICK));
    run_transfer(i2cee_pkg::K_BEGIN_RD, 17'($urandom), 9'd256, 12, 1'b0);

    settle();
    write_reg(i2cee_pkg::CFG_DEV_ADDR, 10'($urandom_range(0, 254)));
    write_reg(i2cee_pkg::CFG_WC_TICKS, 10'($urandom_range(1, 20)));
    idling = 1'b0;
    rx_hold = 90;
    repeat (3) random_sequence();
    wait_drained();
    random_phase(30, 1'b1);

    settle();
    write_reg(i2cee_pkg::CFG_DEV_ADDR, 10'($urandom_range(0, 254)));
    write_reg(i2cee_pkg::CFG_WC_TICKS, 10'($urandom_range(1, 8)));
    random_phase(25, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Ran %0d items (%0d active), %0d commands checked", sb.n_items, useful,
             sb.checked);
    $display("Transfers finished: %0d, aborted: %0d, left unmatched: %0d", sb.n_done,
             sb.n_abort, sb.expected_cmds.size());
    if (sb.mismatches == 0 && sb.expected_cmds.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
